// ----- rtl/usp_pkg.sv -----
// ----------------------------------------------------------------------------
// usp_pkg: shared definitions for the UV sphere point generator
// Widths, configuration register indexes, the CORDIC angle table and the
// sideband type that travels down the pipeline.
// ----------------------------------------------------------------------------
package usp_pkg;

    localparam int MAX_SEGMENTS_DEF   = 256;
    localparam int TRIG_FRAC_BITS_DEF = 14;

    localparam int STEP_W   = 9;                // grid step and segment count width
    localparam int RADIUS_W = 16;
    localparam int POS_W    = 17;
    localparam int IDX_W    = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Phase division: 41-bit numerator, 33 quotient bits, one bit per cell.
    localparam int NUM_W    = 41;
    localparam int QUO_W    = 33;
    localparam int PHASE_W  = 32;

    // CORDIC datapath in Q2.30 with headroom.
    localparam int INNER_FRAC   = 30;
    localparam int CORDIC_ITERS = 30;
    localparam int XY_W         = 34;
    localparam int Z_W          = 33;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

    localparam int POS_LIMIT = 65535;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIUS       = 2'd0,
        REG_LAT_SEGMENTS = 2'd1,
        REG_LON_SEGMENTS = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [STEP_W-1:0] lat_step;
        logic [STEP_W-1:0] lon_step;
        logic [1:0]        quad_t;
        logic [1:0]        quad_p;
    } side_t;

    // Arctangent of 2^-i as a fraction of a full turn, 2^32 per turn.
    function automatic logic [PHASE_W-1:0] atan_turn(input int i);
        logic [PHASE_W-1:0] a;
        case (i)
            0:  a = 32'd536870912;
            1:  a = 32'd316933406;
            2:  a = 32'd167458907;
            3:  a = 32'd85004756;
            4:  a = 32'd42667331;
            5:  a = 32'd21354465;
            6:  a = 32'd10679838;
            7:  a = 32'd5340245;
            8:  a = 32'd2670163;
            9:  a = 32'd1335087;
            10: a = 32'd667544;
            11: a = 32'd333772;
            12: a = 32'd166886;
            13: a = 32'd83443;
            14: a = 32'd41722;
            15: a = 32'd20861;
            16: a = 32'd10430;
            17: a = 32'd5215;
            18: a = 32'd2608;
            19: a = 32'd1304;
            20: a = 32'd652;
            21: a = 32'd326;
            22: a = 32'd163;
            23: a = 32'd81;
            24: a = 32'd41;
            25: a = 32'd20;
            26: a = 32'd10;
            27: a = 32'd5;
            28: a = 32'd3;
            29: a = 32'd1;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

// ----- rtl/usp_if.sv -----
// ----------------------------------------------------------------------------
// usp_if: channel interfaces of the UV sphere point generator
// Grid point input, vertex output and configuration write channels.
// ----------------------------------------------------------------------------
interface usp_grid_if
    import usp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [STEP_W-1:0] lat_step;
    logic [STEP_W-1:0] lon_step;

    modport source (output valid, lat_step, lon_step, input ready);
    modport sink   (input valid, lat_step, lon_step, output ready);
endinterface

interface usp_vertex_if
    import usp_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [IDX_W-1:0]        idx_first;
    logic [IDX_W-1:0]        idx_second;
    logic [IDX_W-1:0]        idx_first_next;
    logic [IDX_W-1:0]        idx_second_next;
    logic                    quad_valid;
    logic                    out_of_range;

    modport source (output valid, pos_x, pos_y, pos_z, idx_first, idx_second,
                    idx_first_next, idx_second_next, quad_valid, out_of_range,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, idx_first, idx_second,
                    idx_first_next, idx_second_next, quad_valid, out_of_range,
                    output ready);
endinterface

interface usp_cfg_if
    import usp_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/usp_div_cell.sv -----
// ----------------------------------------------------------------------------
// usp_div_cell: one restoring division step
// Shifts in the next numerator bit, subtracts the divisor when it fits and
// shifts the quotient bit into the low end of the numerator word.
// ----------------------------------------------------------------------------
module usp_div_cell
    import usp_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [STEP_W-1:0] divisor,
    input  logic [STEP_W-1:0] rem_in,
    input  logic [QUO_W-1:0]  num_in,
    output logic [STEP_W-1:0] rem_reg,
    output logic [QUO_W-1:0]  num_reg
);

    logic [STEP_W:0]   trial;
    logic              fits;
    logic [STEP_W:0]   diff;
    logic [STEP_W-1:0] rem_next;
    logic [QUO_W-1:0]  num_next;

    always_comb
    begin
        trial    = {rem_in, num_in[QUO_W-1]};
        fits     = (trial >= {1'b0, divisor});
        diff     = trial - {1'b0, divisor};
        rem_next = fits ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
        num_next = {num_in[QUO_W-2:0], fits};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            num_reg <= num_next;
        end
    end

endmodule

// ----- rtl/usp_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// usp_cordic_cell: one CORDIC rotation
// Rotates (x, y) by plus or minus atan(2^-STAGE) toward a zero residual angle.
// ----------------------------------------------------------------------------
module usp_cordic_cell
    import usp_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [XY_W-1:0] x_in,
    input  logic signed [XY_W-1:0] y_in,
    input  logic signed [Z_W-1:0]  z_in,
    output logic signed [XY_W-1:0] x_reg,
    output logic signed [XY_W-1:0] y_reg,
    output logic signed [Z_W-1:0]  z_reg
);

    localparam logic signed [Z_W-1:0] ANGLE = Z_W'(atan_turn(STAGE));

    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [XY_W-1:0] x_next;
    logic signed [XY_W-1:0] y_next;
    logic signed [Z_W-1:0]  z_next;

    always_comb
    begin
        dx = y_in >>> STAGE;
        dy = x_in >>> STAGE;
        if (!z_in[Z_W-1])
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ANGLE;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ANGLE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

endmodule

// ----- rtl/uv_sphere_point_generator.sv -----
// ----------------------------------------------------------------------------
// uv_sphere_point_generator: UV sphere vertex and quad index generator
// Maps one latitude/longitude grid step to a Q8.8 vertex position and the
// vertex numbers of the quad that the point owns.
// ----------------------------------------------------------------------------
//
//   Channel  Role   Payload                                      Transfer when
//   -------  -----  -------------------------------------------  ---------------
//   cfg      sink   index, data (radius, lat/lon segment count)  valid & ready
//   grid     sink   lat_step, lon_step                           valid & ready
//   vertex   source pos_x/y/z, four indices, quad_valid, flag    valid & ready
//
// One grid point is taken per cycle unless the pipeline stalls. A point passes
// through 33 cells of the phase divider (one quotient bit each), 30 CORDIC cells,
// the rounding and multiplication stages A, B and C, and the output register.
// Reset (rst_n, asynchronous) clears every stage valid and loads the register
// defaults radius 1.0, 16 bands and 32 slices.
// The whole pipeline stalls as one only when the output register is held and
// the last arithmetic stage carries an item; otherwise every stage moves each
// cycle, so a bubble in the last stage lets the earlier stages close up.
// ----------------------------------------------------------------------------
module uv_sphere_point_generator
    import usp_pkg::*;
#(
    parameter int MAX_SEGMENTS   = MAX_SEGMENTS_DEF,
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    usp_cfg_if.sink       cfg,
    usp_grid_if.sink      grid,
    usp_vertex_if.source  vertex
);

    // Pipeline geometry.
    localparam int DIV_ST  = QUO_W;
    localparam int PIPE_ST = DIV_ST + CORDIC_ITERS;

    // Sine/cosine in Q(TF) with room for +1.0 and its sign.
    localparam int TW = TRIG_FRAC_BITS + 2;
    localparam int SH = INNER_FRAC - TRIG_FRAC_BITS;
    // radius (17 bit signed) times a sine or cosine
    localparam int RW = POS_W + TW;
    // radius times sine times cosine
    localparam int XW = RW + TW;

    localparam logic signed [XY_W-1:0] TRIG_HALF = XY_W'(1) <<< (SH - 1);
    localparam logic signed [XY_W-1:0] TRIG_ONE  = XY_W'(1) <<< TRIG_FRAC_BITS;

    // ------------------------------------------------------------------
    // Configuration registers. The user must write them only while the block is
    // idle; the block itself has no check for this. Every stage reads them directly.
    // ------------------------------------------------------------------
    logic [RADIUS_W-1:0] radius_reg;
    logic [STEP_W-1:0]   lat_seg_reg;
    logic [STEP_W-1:0]   lon_seg_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= RADIUS_W'(256);
            lat_seg_reg <= STEP_W'(16);
            lon_seg_reg <= STEP_W'(32);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_RADIUS:       radius_reg  <= cfg.data;
                REG_LAT_SEGMENTS: lat_seg_reg <= cfg.data[STEP_W-1:0];
                REG_LON_SEGMENTS: lon_seg_reg <= cfg.data[STEP_W-1:0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control. The pipeline advances unless a finished item waits in
    // the output register and another is ready to replace it.
    // ------------------------------------------------------------------
    logic adv;
    logic out_valid_reg;
    logic vld_c_reg;

    assign adv        = !out_valid_reg || vertex.ready || !vld_c_reg;
    assign grid.ready = adv;

    // Sideband and valid bits run beside the divider and CORDIC cells.
    logic  vld_pipe  [0:PIPE_ST];
    side_t side_pipe [0:PIPE_ST];
    side_t side_d    [0:PIPE_ST-1];

    assign vld_pipe[0]           = grid.valid;
    assign side_pipe[0].lat_step = grid.lat_step;
    assign side_pipe[0].lon_step = grid.lon_step;
    assign side_pipe[0].quad_t   = 2'b00;
    assign side_pipe[0].quad_p   = 2'b00;

    // ------------------------------------------------------------------
    // Phase division: theta = round(lat * 2^31 / N), phi = round(lon * 2^32 / M).
    // The top eight numerator bits are already below the divisor, so the
    // chain only needs one cell per quotient bit.
    // ------------------------------------------------------------------
    logic [STEP_W-1:0] t_rem [0:DIV_ST];
    logic [QUO_W-1:0]  t_num [0:DIV_ST];
    logic [STEP_W-1:0] p_rem [0:DIV_ST];
    logic [QUO_W-1:0]  p_num [0:DIV_ST];
    logic [NUM_W-1:0]  dnum_t;
    logic [NUM_W-1:0]  dnum_p;

    always_comb
    begin
        dnum_t = {1'b0, grid.lat_step, 31'b0} + NUM_W'(lat_seg_reg >> 1);
        dnum_p = {grid.lon_step, 32'b0} + NUM_W'(lon_seg_reg >> 1);
    end

    assign t_rem[0] = {1'b0, dnum_t[NUM_W-1:QUO_W]};
    assign t_num[0] = dnum_t[QUO_W-1:0];
    assign p_rem[0] = {1'b0, dnum_p[NUM_W-1:QUO_W]};
    assign p_num[0] = dnum_p[QUO_W-1:0];

    for (genvar k = 0; k < DIV_ST; k++)
    begin : g_div
        usp_div_cell u_div_t (
            .clk     (clk),
            .en      (adv),
            .divisor (lat_seg_reg),
            .rem_in  (t_rem[k]),
            .num_in  (t_num[k]),
            .rem_reg (t_rem[k+1]),
            .num_reg (t_num[k+1])
        );
        usp_div_cell u_div_p (
            .clk     (clk),
            .en      (adv),
            .divisor (lon_seg_reg),
            .rem_in  (p_rem[k]),
            .num_in  (p_num[k]),
            .rem_reg (p_rem[k+1]),
            .num_reg (p_num[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Quadrant split: the phase is reduced to a residual in [-45, 45)
    // degrees and the quadrant rides along to undo the reduction later.
    // ------------------------------------------------------------------
    logic [PHASE_W-1:0] phase_t;
    logic [PHASE_W-1:0] phase_p;
    logic [PHASE_W-1:0] rot_t;
    logic [PHASE_W-1:0] rot_p;
    logic [1:0]         quad_t;
    logic [1:0]         quad_p;
    logic [PHASE_W-1:0] resid_t;
    logic [PHASE_W-1:0] resid_p;

    always_comb
    begin
        phase_t = t_num[DIV_ST][PHASE_W-1:0];
        phase_p = p_num[DIV_ST][PHASE_W-1:0];
        rot_t   = phase_t + 32'h2000_0000;
        rot_p   = phase_p + 32'h2000_0000;
        quad_t  = rot_t[PHASE_W-1:PHASE_W-2];
        quad_p  = rot_p[PHASE_W-1:PHASE_W-2];
        resid_t = phase_t - {quad_t, 30'b0};
        resid_p = phase_p - {quad_p, 30'b0};
    end

    for (genvar k = 0; k < PIPE_ST; k++)
    begin : g_side
        if (k == DIV_ST)
        begin : g_quad
            always_comb
            begin
                side_d[k]        = side_pipe[k];
                side_d[k].quad_t = quad_t;
                side_d[k].quad_p = quad_p;
            end
        end
        else
        begin : g_pass
            assign side_d[k] = side_pipe[k];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_pipe[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_pipe[k+1] <= vld_pipe[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_pipe[k+1] <= side_d[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // CORDIC rotation chains, one for theta and one for phi. The start
    // vector carries the inverse gain so the result needs no scaling.
    // ------------------------------------------------------------------
    logic signed [XY_W-1:0] cx_t [0:CORDIC_ITERS];
    logic signed [XY_W-1:0] cy_t [0:CORDIC_ITERS];
    logic signed [Z_W-1:0]  cz_t [0:CORDIC_ITERS];
    logic signed [XY_W-1:0] cx_p [0:CORDIC_ITERS];
    logic signed [XY_W-1:0] cy_p [0:CORDIC_ITERS];
    logic signed [Z_W-1:0]  cz_p [0:CORDIC_ITERS];

    assign cx_t[0] = CORDIC_GAIN;
    assign cy_t[0] = '0;
    assign cz_t[0] = {resid_t[PHASE_W-1], resid_t};
    assign cx_p[0] = CORDIC_GAIN;
    assign cy_p[0] = '0;
    assign cz_p[0] = {resid_p[PHASE_W-1], resid_p};

    for (genvar j = 0; j < CORDIC_ITERS; j++)
    begin : g_cordic
        usp_cordic_cell #(.STAGE(j)) u_rot_t (
            .clk   (clk),
            .en    (adv),
            .x_in  (cx_t[j]),
            .y_in  (cy_t[j]),
            .z_in  (cz_t[j]),
            .x_reg (cx_t[j+1]),
            .y_reg (cy_t[j+1]),
            .z_reg (cz_t[j+1])
        );
        usp_cordic_cell #(.STAGE(j)) u_rot_p (
            .clk   (clk),
            .en    (adv),
            .x_in  (cx_p[j]),
            .y_in  (cy_p[j]),
            .z_in  (cz_p[j]),
            .x_reg (cx_p[j+1]),
            .y_reg (cy_p[j+1]),
            .z_reg (cz_p[j+1])
        );
    end

    // Rounds a Q2.30 value to Q(TF), half up, and clamps it to [-1, +1].
    function automatic logic signed [TW-1:0] trig_round(input logic signed [XY_W-1:0] v);
        logic signed [XY_W-1:0] t;
        t = (v + TRIG_HALF) >>> SH;
        if (t > TRIG_ONE)
        begin
            t = TRIG_ONE;
        end
        else if (t < -TRIG_ONE)
        begin
            t = -TRIG_ONE;
        end
        return t[TW-1:0];
    endfunction

    // Rounds a product down by sh bits, half up, and saturates to +-65535.
    function automatic logic signed [POS_W-1:0] pos_round(input logic signed [XW-1:0] v,
                                                          input int sh);
        logic signed [XW-1:0] half;
        logic signed [XW-1:0] t;
        half = XW'(1) <<< (sh - 1);
        t    = (v + half) >>> sh;
        if (t > XW'(POS_LIMIT))
        begin
            t = XW'(POS_LIMIT);
        end
        else if (t < -XW'(POS_LIMIT))
        begin
            t = -XW'(POS_LIMIT);
        end
        return t[POS_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Stage A: undo the quadrant reduction, then round the sines and cosines of both angles.
    // ------------------------------------------------------------------
    logic                   vld_a_reg;
    side_t                  side_a_reg;
    logic signed [TW-1:0]   st_reg, ct_reg, sp_reg, cp_reg;
    logic signed [XY_W-1:0] cos_t, sin_t, cos_p, sin_p;

    always_comb
    begin
        case (side_pipe[PIPE_ST].quad_t)
            2'd0:    begin cos_t =  cx_t[CORDIC_ITERS]; sin_t =  cy_t[CORDIC_ITERS]; end
            2'd1:    begin cos_t = -cy_t[CORDIC_ITERS]; sin_t =  cx_t[CORDIC_ITERS]; end
            2'd2:    begin cos_t = -cx_t[CORDIC_ITERS]; sin_t = -cy_t[CORDIC_ITERS]; end
            default: begin cos_t =  cy_t[CORDIC_ITERS]; sin_t = -cx_t[CORDIC_ITERS]; end
        endcase
        case (side_pipe[PIPE_ST].quad_p)
            2'd0:    begin cos_p =  cx_p[CORDIC_ITERS]; sin_p =  cy_p[CORDIC_ITERS]; end
            2'd1:    begin cos_p = -cy_p[CORDIC_ITERS]; sin_p =  cx_p[CORDIC_ITERS]; end
            2'd2:    begin cos_p = -cx_p[CORDIC_ITERS]; sin_p = -cy_p[CORDIC_ITERS]; end
            default: begin cos_p =  cy_p[CORDIC_ITERS]; sin_p = -cx_p[CORDIC_ITERS]; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_a_reg <= side_pipe[PIPE_ST];
            st_reg     <= trig_round(sin_t);
            ct_reg     <= trig_round(cos_t);
            sp_reg     <= trig_round(sin_p);
            cp_reg     <= trig_round(cos_p);
        end
    end

    // ------------------------------------------------------------------
    // Stage B: radius products and the vertex numbers.
    // ------------------------------------------------------------------
    logic                    vld_b_reg;
    side_t                   side_b_reg;
    logic signed [RW-1:0]    rst_reg, rct_reg;
    logic signed [TW-1:0]    sp_b_reg, cp_b_reg;
    logic [IDX_W-1:0]        first_reg, second_reg;
    logic signed [POS_W-1:0] rad_s;
    logic [18:0]             first_full;
    logic [IDX_W-1:0]        first_next, second_next;

    always_comb
    begin
        rad_s       = signed'({1'b0, radius_reg});
        first_full  = 19'(side_a_reg.lat_step) * (19'(lon_seg_reg) + 19'd1)
                    + 19'(side_a_reg.lon_step);
        first_next  = first_full[IDX_W-1:0];
        second_next = first_next + IDX_W'(lon_seg_reg) + IDX_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_b_reg <= side_a_reg;
            rst_reg    <= rad_s * st_reg;
            rct_reg    <= rad_s * ct_reg;
            sp_b_reg   <= sp_reg;
            cp_b_reg   <= cp_reg;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: second products for x and z, y rounded.
    // ------------------------------------------------------------------
    side_t                   side_c_reg;
    logic signed [XW-1:0]    xp_reg, zp_reg;
    logic signed [POS_W-1:0] y_c_reg;
    logic [IDX_W-1:0]        first_c_reg, second_c_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_c_reg   <= side_b_reg;
            xp_reg       <= rst_reg * cp_b_reg;
            zp_reg       <= rst_reg * sp_b_reg;
            y_c_reg      <= pos_round(XW'(rct_reg), TRIG_FRAC_BITS);
            first_c_reg  <= first_reg;
            second_c_reg <= second_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_a_reg <= vld_pipe[PIPE_ST];
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage D, the output register: x and z rounded, range checks applied.
    // A bad segment count or a step past the grid flags the point and zeros
    // everything else; a point on the last band or slice owns no quad.
    // ------------------------------------------------------------------
    logic out_bad;
    logic out_quad;
    logic load_out;

    always_comb
    begin
        out_bad  = (lat_seg_reg == '0) || (lon_seg_reg == '0)
                || (32'(lat_seg_reg) > MAX_SEGMENTS) || (32'(lon_seg_reg) > MAX_SEGMENTS)
                || (side_c_reg.lat_step > lat_seg_reg)
                || (side_c_reg.lon_step > lon_seg_reg);
        out_quad = !out_bad && (side_c_reg.lat_step < lat_seg_reg)
                && (side_c_reg.lon_step < lon_seg_reg);
        load_out = adv && vld_c_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (vertex.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            vertex.pos_x           <= out_bad ? '0 : pos_round(xp_reg, 2 * TRIG_FRAC_BITS);
            vertex.pos_y           <= out_bad ? '0 : y_c_reg;
            vertex.pos_z           <= out_bad ? '0 : pos_round(zp_reg, 2 * TRIG_FRAC_BITS);
            vertex.idx_first       <= out_bad ? '0 : first_c_reg;
            vertex.idx_second      <= out_quad ? second_c_reg : '0;
            vertex.idx_first_next  <= out_quad ? first_c_reg + IDX_W'(1) : '0;
            vertex.idx_second_next <= out_quad ? second_c_reg + IDX_W'(1) : '0;
            vertex.quad_valid      <= out_quad;
            vertex.out_of_range    <= out_bad;
        end
    end

    assign vertex.valid = out_valid_reg;

    // ------------------------------------------------------------------
    // Checks on the pipeline control and the output masking.
    // ------------------------------------------------------------------
    a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
        vertex.valid |-> !(vertex.quad_valid && vertex.out_of_range))
        else $error("quad_valid and out_of_range both set");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (vertex.valid && vertex.out_of_range) |->
            (vertex.pos_x == '0 && vertex.pos_y == '0 && vertex.pos_z == '0
             && vertex.idx_first == '0))
        else $error("flagged point carries nonzero fields");

    a_noquad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (vertex.valid && !vertex.quad_valid) |->
            (vertex.idx_second == '0 && vertex.idx_first_next == '0
             && vertex.idx_second_next == '0))
        else $error("quad indices set without a quad");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !vertex.ready && vld_c_reg) |-> !grid.ready)
        else $error("input taken while pipeline is blocked");

    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !vertex.ready) |=> out_valid_reg)
        else $error("held result dropped");

endmodule

// ----- test/uv_sphere_point_generator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uv_sphere_point_generator_tb: self-checking bench for the sphere generator
// Drives grid points through the valid/ready channels, computes each vertex
// and its quad indices with a bit-exact CORDIC predictor, and compares every
// transfer on the vertex channel field by field. The grid and vertex sides
// idle and stall at random in several phases, and the segment counts and
// radius move through several settings between phases.
// ----------------------------------------------------------------------------
module uv_sphere_point_generator_tb;
    import usp_pkg::*;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [IDX_W-1:0]        idx_first;
        logic [IDX_W-1:0]        idx_second;
        logic [IDX_W-1:0]        idx_first_next;
        logic [IDX_W-1:0]        idx_second_next;
        logic                    quad_valid;
        logic                    out_of_range;
    } vertex_t;

    // The pipeline is 67 stages deep; the drain wait leaves a margin on that.
    localparam int PIPE_DEPTH  = 67;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;

    usp_cfg_if    cfg ();
    usp_grid_if   grid ();
    usp_vertex_if vertex ();

    uv_sphere_point_generator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .grid   (grid),
        .vertex (vertex)
    );

    // Shadow copies of the block's registers, updated on each cfg transfer.
    logic [RADIUS_W-1:0] sh_radius;
    logic [STEP_W-1:0]   sh_lat_segs;
    logic [STEP_W-1:0]   sh_lon_segs;

    vertex_t pending_vertices[$];
    int      mismatch_count;
    int      cycle_count;
    int      grid_idle_pct;
    int      vertex_stall_pct;
    int      hold_off_cycles;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Rounds a Q2.30 value or a product by half up and floor shift.
    function automatic longint round_half_up(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_mag(input longint v, input longint lim);
        if (v > lim)
        begin
            return lim;
        end
        if (v < -lim)
        begin
            return -lim;
        end
        return v;
    endfunction

    // Sine and cosine of a 32-bit turn phase in Q14 through a 30-step CORDIC.
    task automatic cordic_sin_cos(input logic [31:0] phase, output longint sin_q,
                                  output longint cos_q);
        logic [1:0]  quadrant;
        logic [31:0] resid;
        longint      cx;
        longint      cy;
        longint      cz;
        longint      dx;
        longint      dy;
        longint      c;
        longint      s;
        longint      one;
        quadrant = 2'((phase + 32'h2000_0000) >> 30);
        resid    = phase - {quadrant, 30'd0};
        cz       = longint'($signed(resid));
        cx       = 652032874;
        cy       = 0;
        for (int i = 0; i < CORDIC_ITERS; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cz >= 0)
            begin
                cx -= dx;
                cy += dy;
                cz -= longint'(atan_turn(i));
            end
            else
            begin
                cx += dx;
                cy -= dy;
                cz += longint'(atan_turn(i));
            end
        end
        case (quadrant)
            2'd0:    begin c = cx;  s = cy;  end
            2'd1:    begin c = -cy; s = cx;  end
            2'd2:    begin c = -cx; s = -cy; end
            default: begin c = cy;  s = -cx; end
        endcase
        one   = longint'(1) << TRIG_FRAC_BITS_DEF;
        cos_q = clamp_mag(round_half_up(c, INNER_FRAC - TRIG_FRAC_BITS_DEF), one);
        sin_q = clamp_mag(round_half_up(s, INNER_FRAC - TRIG_FRAC_BITS_DEF), one);
    endtask

    // Expected vertex for one grid point under the current register values.
    task automatic compute_vertex(input logic [STEP_W-1:0] lat, input logic [STEP_W-1:0] lon,
                                  output vertex_t v);
        longint n;
        longint m;
        longint ph_t;
        longint ph_p;
        longint st;
        longint ct;
        longint sp;
        longint cp;
        longint r;
        longint first;
        longint second;
        n = sh_lat_segs;
        m = sh_lon_segs;
        v = '0;
        if (n == 0 || m == 0 || n > MAX_SEGMENTS_DEF || m > MAX_SEGMENTS_DEF ||
            lat > n || lon > m)
        begin
            v.out_of_range = 1'b1;
            return;
        end
        ph_t = ((longint'(lat) << 31) + n / 2) / n;
        ph_p = ((longint'(lon) << 32) + m / 2) / m;
        cordic_sin_cos(32'(ph_t), st, ct);
        cordic_sin_cos(32'(ph_p), sp, cp);
        r       = sh_radius;
        v.pos_y = POS_W'(clamp_mag(round_half_up(r * ct, TRIG_FRAC_BITS_DEF), POS_LIMIT));
        v.pos_x = POS_W'(clamp_mag(round_half_up(r * st * cp, 2 * TRIG_FRAC_BITS_DEF),
                                   POS_LIMIT));
        v.pos_z = POS_W'(clamp_mag(round_half_up(r * st * sp, 2 * TRIG_FRAC_BITS_DEF),
                                   POS_LIMIT));
        first       = lat * (m + 1) + lon;
        second      = first + m + 1;
        v.idx_first = IDX_W'(first);
        if (lat < n && lon < m)
        begin
            v.idx_second      = IDX_W'(second);
            v.idx_first_next  = IDX_W'(first + 1);
            v.idx_second_next = IDX_W'(second + 1);
            v.quad_valid      = 1'b1;
        end
    endtask

    // Offers one grid point, idling first at the current rate, and records the
    // expected vertex at the transfer. Valid stays up after the transfer so
    // that back-to-back points follow without a gap.
    task automatic send_grid_point(input logic [STEP_W-1:0] lat, input logic [STEP_W-1:0] lon);
        vertex_t v;
        while ($urandom_range(99) < grid_idle_pct)
        begin
            grid.valid <= 1'b0;
            @(posedge clk);
        end
        grid.valid    <= 1'b1;
        grid.lat_step <= lat;
        grid.lon_step <= lon;
        do
        begin
            @(posedge clk);
        end
        while (!grid.ready);
        compute_vertex(lat, lon, v);
        pending_vertices = {pending_vertices, v};
    endtask

    // Waits until every expected vertex has arrived, plus the pipeline depth.
    task automatic drain_pipeline();
        grid.valid <= 1'b0;
        while (pending_vertices.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_DEPTH + 8) @(posedge clk);
    endtask

    task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg.ready);
        case (idx)
            REG_RADIUS:       sh_radius   = value;
            REG_LAT_SEGMENTS: sh_lat_segs = STEP_W'(value);
            REG_LON_SEGMENTS: sh_lon_segs = STEP_W'(value);
            default:          ;
        endcase
    endtask

    task automatic set_sphere(input int radius, input int lat_segs, input int lon_segs);
        drain_pipeline();
        write_register(REG_RADIUS, CFG_DATA_W'(radius));
        write_register(REG_LAT_SEGMENTS, CFG_DATA_W'(lat_segs));
        write_register(REG_LON_SEGMENTS, CFG_DATA_W'(lon_segs));
        cfg.valid <= 1'b0;
    endtask

    // Pole, equator, seam and out-of-range points on the reset sphere, then
    // the extremes of the steps and of the register values.
    task automatic test_directed_points();
        send_grid_point(0, 0);
        send_grid_point(16, 32);
        send_grid_point(8, 0);
        send_grid_point(8, 8);
        send_grid_point(15, 31);
        send_grid_point(16, 5);
        send_grid_point(3, 32);
        send_grid_point(17, 0);
        send_grid_point(0, 33);
        send_grid_point(511, 511);
        send_grid_point(256, 256);
        set_sphere(65535, 256, 256);
        send_grid_point(128, 64);
        send_grid_point(256, 256);
        send_grid_point(255, 255);
        send_grid_point(64, 0);
        send_grid_point(257, 0);
        set_sphere(0, 1, 1);
        send_grid_point(0, 0);
        send_grid_point(1, 1);
        send_grid_point(1, 0);
        // Segment counts of zero or above the limit turn every point away.
        set_sphere(256, 0, 4);
        send_grid_point(0, 0);
        set_sphere(256, 4, 257);
        send_grid_point(1, 1);
        set_sphere(256, 511, 4);
        send_grid_point(2, 2);
    endtask

    // Mostly in-range points of the current grid, with some strays beyond it.
    task automatic random_points(input int count);
        int lat;
        int lon;
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(9) < 8)
            begin
                lat = $urandom_range(sh_lat_segs);
                lon = $urandom_range(sh_lon_segs);
            end
            else
            begin
                lat = $urandom_range(511);
                lon = $urandom_range(511);
            end
            send_grid_point(STEP_W'(lat), STEP_W'(lon));
        end
    endtask

    task automatic test_random_sweep();
        int settings[6][3] = '{'{256, 16, 32}, '{65535, 256, 256}, '{1, 2, 3},
                               '{12345, 97, 181}, '{40000, 255, 7}, '{0, 5, 256}};
        int phase_idle[4]  = '{0, 63, 0, 34};
        int phase_stall[4] = '{0, 0, 63, 34};
        for (int s = 0; s < 6; s++)
        begin
            set_sphere(settings[s][0], settings[s][1], settings[s][2]);
            for (int p = 0; p < 4; p++)
            begin
                grid_idle_pct    = phase_idle[p];
                vertex_stall_pct = phase_stall[p];
                random_points(75);
            end
        end
        grid_idle_pct    = 0;
        vertex_stall_pct = 0;
    endtask

    // The vertex side holds off long enough for the pipeline to fill and
    // stall the grid side while it keeps offering points.
    task automatic test_backpressure();
        set_sphere($urandom_range(65535), $urandom_range(256, 1), $urandom_range(256, 1));
        hold_off_cycles = 300;
        random_points(150);
    endtask

    // Counts down a requested hold-off on the vertex side.
    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
        end
    end

    // Vertex channel: random stalls, the long hold-off, and checking.
    always @(posedge clk)
    begin
        vertex_t exp_v;
        vertex_t got_v;
        if (hold_off_cycles > 0)
        begin
            vertex.ready <= 1'b0;
        end
        else
        begin
            vertex.ready <= ($urandom_range(99) >= vertex_stall_pct);
        end
        if (rst_n && vertex.valid && vertex.ready)
        begin
            got_v = '{vertex.pos_x, vertex.pos_y, vertex.pos_z, vertex.idx_first,
                      vertex.idx_second, vertex.idx_first_next, vertex.idx_second_next,
                      vertex.quad_valid, vertex.out_of_range};
            if (pending_vertices.size() == 0)
            begin
                $display("%0t: unexpected vertex transfer %h", $time, got_v);
                mismatch_count++;
            end
            else
            begin
                exp_v = pending_vertices.pop_front();
                if (got_v !== exp_v)
                begin
                    $display("%0t: vertex mismatch expected %p actual %p", $time, exp_v, got_v);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("uv_sphere_point_generator verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        cycle_count      = 0;
        mismatch_count   = 0;
        grid_idle_pct    = 0;
        vertex_stall_pct = 0;
        hold_off_cycles  = 0;
        sh_radius        = 16'd256;
        sh_lat_segs      = 9'd16;
        sh_lon_segs      = 9'd32;
        grid.valid       = 1'b0;
        grid.lat_step    = '0;
        grid.lon_step    = '0;
        cfg.valid        = 1'b0;
        cfg.index        = REG_RADIUS;
        cfg.data         = '0;
        vertex.ready     = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_points();
        test_random_sweep();
        test_backpressure();
        drain_pipeline();
        if (mismatch_count == 0 && pending_vertices.size() == 0)
        begin
            $display("uv_sphere_point_generator verification clean");
        end
        else
        begin
            $display("uv_sphere_point_generator verification failed");
        end
        $finish;
    end
endmodule
